### rtl/core/lbq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and memory request types for the linked-block byte queue manager.
// No dependencies.
package lbq_pkg;

  localparam int BLOCK_BYTES = 32;
  localparam int NUM_BLOCKS  = 256;
  localparam int NUM_QUEUES  = 8;
  localparam int POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;

  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int POS_W  = OFF_W + BLK_W;
  localparam int IDX_W  = OFF_W + 1;

  localparam int CMD_W  = 3;
  localparam int QID_W  = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 14;
  localparam int STAT_W = 2;
  localparam int FREE_W = 9;

  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd2;

  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic [BLK_W-1:0] wdata;
    logic [BLK_W-1:0] raddr;
  } lbq_link_req_t;

  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [POS_W-1:0]  raddr;
  } lbq_byte_req_t;

endpackage

### rtl/core/lbq_ifs.sv
`timescale 1ns / 1ps
// Command and response channel interfaces (valid/ready).
// Depends on lbq_pkg.
interface lbq_cmd_if;
  import lbq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [QID_W-1:0]  queue_id;
  logic [BYTE_W-1:0] data_in;
  logic [LEN_W-1:0]  byte_count;
  logic [BYTE_W-1:0] stop_mask;
  modport source (output valid, cmd, queue_id, data_in, byte_count, stop_mask, input ready);
  modport sink   (input valid, cmd, queue_id, data_in, byte_count, stop_mask, output ready);
endinterface

interface lbq_rsp_if;
  import lbq_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  count_out;
  logic [FREE_W-1:0] free_blocks;
  modport source (output valid, data_out, status, count_out, free_blocks, input ready);
  modport sink   (input valid, data_out, status, count_out, free_blocks, output ready);
endinterface

### rtl/core/lbq_byte_ram.sv
`timescale 1ns / 1ps
// Byte pool storage: one write and one registered read per cycle.
// Depends on lbq_pkg.
module lbq_byte_ram (
  input  logic                  clk_i,
  input  lbq_pkg::lbq_byte_req_t req_i,
  output logic [lbq_pkg::BYTE_W-1:0] rdata_o
);
  import lbq_pkg::*;

  logic [BYTE_W-1:0] mem_q [POOL_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lbq_link_ram.sv
`timescale 1ns / 1ps
// Block link storage with per-entry valid bits; unwritten entries read as index + 1.
// Depends on lbq_pkg.
module lbq_link_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lbq_pkg::lbq_link_req_t req_i,
  output logic [lbq_pkg::BLK_W-1:0] rdata_o
);
  import lbq_pkg::*;

  logic [BLK_W-1:0]      mem_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_q;
  logic [BLK_W-1:0]      rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    // reset chain: block i links to i+1, wrapping
    rdata_q <= valid_q[req_i.raddr] ? mem_q[req_i.raddr] : req_i.raddr + BLK_W'(1);
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/linked_block_byte_queue_manager_top.sv
`timescale 1ns / 1ps
// Linked-block byte queue manager: command sequencer, free list and per-queue state.
// Depends on lbq_pkg, lbq_ifs, lbq_byte_ram, lbq_link_ram.
//
//   channel  dir  modport  carries
//   cmd_i    in   sink     cmd, queue_id, data_in, byte_count, stop_mask
//   rsp_o    out  source   data_out, status, count_out, free_blocks
//
// One command at a time: S_EXEC, then S_FINISH loads the result register and S_IDLE
// accepts again. Put taking a block adds S_PUT_TAKE, get S_GET_RD, remove-last S_REM_RD.
// Remove-last on a block boundary walks the chain from the head; flush repeats S_FL_EVAL,
// S_FL_LINK per drained block, a masked contiguous count S_CNT_SCAN, S_CNT_CHK per byte.
// Reset is immediate: link valid bits give the initial free chain, no clearing pass.
// A result waiting on rsp_o does not block accepting the next command.
module linked_block_byte_queue_manager_top (
  input  logic clk_i,
  input  logic rst_ni,
  lbq_cmd_if.sink   cmd_i,
  lbq_rsp_if.source rsp_o
);
  import lbq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_PUT_TAKE, S_GET_RD, S_REM_RD, S_REM_WALK,
    S_FL_EVAL, S_FL_LINK, S_CNT_SCAN, S_CNT_CHK, S_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [QID_W-1:0]  qid_q, qid_d;
  logic [BYTE_W-1:0] din_q, din_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] mask_q, mask_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  head_q, head_d;
  logic [POS_W-1:0]  tail_q, tail_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [BLK_W-1:0]  walk_q, walk_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BLK_W-1:0]  free_head_q, free_head_d;
  logic [FREE_W-1:0] free_total_q, free_total_d;

  logic              rsp_valid_q, rsp_valid_d;
  logic [BYTE_W-1:0] rsp_data_q, rsp_data_d;
  logic [STAT_W-1:0] rsp_status_q, rsp_status_d;
  logic [LEN_W-1:0]  rsp_count_q, rsp_count_d;
  logic [FREE_W-1:0] rsp_free_q, rsp_free_d;

  logic [LEN_W-1:0] qlen_q  [NUM_QUEUES];
  logic [POS_W-1:0] qhead_q [NUM_QUEUES];
  logic [POS_W-1:0] qtail_q [NUM_QUEUES];
  logic             commit;

  lbq_link_req_t     link_req;
  lbq_byte_req_t     byte_req;
  logic [BLK_W-1:0]  link_rdata;
  logic [BYTE_W-1:0] byte_rdata;

  lbq_link_ram u_link (.clk_i, .rst_ni, .req_i(link_req), .rdata_o(link_rdata));
  lbq_byte_ram u_byte (.clk_i, .req_i(byte_req), .rdata_o(byte_rdata));

  logic [OFF_W-1:0] off_h, off_t;
  logic [BLK_W-1:0] blk_h, blk_t;
  logic [IDX_W-1:0] rem_raw, lead;
  logic [LEN_W-1:0] rem, lead_len;

  assign off_h = head_q[OFF_W-1:0];
  assign off_t = tail_q[OFF_W-1:0];
  assign blk_h = head_q[POS_W-1:OFF_W];
  assign blk_t = tail_q[POS_W-1:OFF_W];
  assign lead  = IDX_W'(BLOCK_BYTES) - {1'b0, off_h};

  // bytes left in the head block, clipped to the queue length
  always_comb begin
    if (blk_h == blk_t && off_t >= off_h) begin
      rem_raw = {1'b0, off_t} - {1'b0, off_h} + IDX_W'(1);
    end else begin
      rem_raw = lead;
    end
    rem      = (LEN_W'(rem_raw) > len_q) ? len_q : LEN_W'(rem_raw);
    lead_len = (LEN_W'(lead) > len_q) ? len_q : LEN_W'(lead);
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.data_out    = rsp_data_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.count_out   = rsp_count_q;
  assign rsp_o.free_blocks = rsp_free_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    qid_d        = qid_q;
    din_d        = din_q;
    cnt_d        = cnt_q;
    mask_d       = mask_q;
    len_d        = len_q;
    head_d       = head_q;
    tail_d       = tail_q;
    data_d       = data_q;
    status_d     = status_q;
    count_d      = count_q;
    walk_d       = walk_q;
    idx_d        = idx_q;
    free_head_d  = free_head_q;
    free_total_d = free_total_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_data_d   = rsp_data_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    rsp_free_d   = rsp_free_q;
    commit       = 1'b0;
    link_req     = '0;
    byte_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d    = cmd_i.cmd;
          qid_d    = cmd_i.queue_id;
          din_d    = cmd_i.data_in;
          cnt_d    = cmd_i.byte_count;
          mask_d   = cmd_i.stop_mask;
          len_d    = qlen_q[cmd_i.queue_id];
          head_d   = qhead_q[cmd_i.queue_id];
          tail_d   = qtail_q[cmd_i.queue_id];
          data_d   = '0;
          status_d = STAT_OK;
          count_d  = '0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_FINISH;
        case (cmd_q)
          CMD_PUT: begin
            if (len_q == '0 || off_t == {OFF_W{1'b1}}) begin
              if (free_total_q == '0) begin
                status_d = STAT_NOFREE;
              end else begin
                link_req.raddr = free_head_q;
                state_d        = S_PUT_TAKE;
              end
            end else begin
              tail_d         = tail_q + POS_W'(1);
              byte_req.we    = 1'b1;
              byte_req.waddr = tail_q + POS_W'(1);
              byte_req.wdata = din_q;
              len_d          = len_q + LEN_W'(1);
            end
          end
          CMD_GET: begin
            if (len_q == '0) begin
              status_d = STAT_EMPTY;
            end else begin
              byte_req.raddr = head_q;
              link_req.raddr = blk_h;
              state_d        = S_GET_RD;
            end
          end
          CMD_REMOVE: begin
            if (len_q == '0) begin
              status_d = STAT_EMPTY;
            end else begin
              byte_req.raddr = tail_q;
              state_d        = S_REM_RD;
            end
          end
          CMD_FLUSH: begin
            state_d = S_FL_EVAL;
          end
          CMD_COUNT: begin
            if (len_q != '0) begin
              count_d = lead_len;
              idx_d   = '0;
              if (mask_q != '0) begin
                state_d = S_CNT_SCAN;
              end
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end

      S_PUT_TAKE: begin
        free_head_d  = link_rdata;
        free_total_d = free_total_q - FREE_W'(1);
        if (len_q == '0) begin
          head_d = {free_head_q, {OFF_W{1'b0}}};
        end else begin
          link_req.we    = 1'b1;
          link_req.waddr = blk_t;
          link_req.wdata = free_head_q;
        end
        tail_d         = {free_head_q, {OFF_W{1'b0}}};
        byte_req.we    = 1'b1;
        byte_req.waddr = {free_head_q, {OFF_W{1'b0}}};
        byte_req.wdata = din_q;
        len_d          = len_q + LEN_W'(1);
        state_d        = S_FINISH;
      end

      S_GET_RD: begin
        data_d = byte_rdata;
        len_d  = len_q - LEN_W'(1);
        if (len_q == LEN_W'(1) || off_h == {OFF_W{1'b1}}) begin
          link_req.we    = 1'b1;
          link_req.waddr = blk_h;
          link_req.wdata = free_head_q;
          free_head_d    = blk_h;
          free_total_d   = free_total_q + FREE_W'(1);
          head_d         = {link_rdata, {OFF_W{1'b0}}};
        end else begin
          head_d = head_q + POS_W'(1);
        end
        state_d = S_FINISH;
      end

      S_REM_RD: begin
        data_d  = byte_rdata;
        len_d   = len_q - LEN_W'(1);
        state_d = S_FINISH;
        if (len_q == LEN_W'(1)) begin
          link_req.we    = 1'b1;
          link_req.waddr = blk_t;
          link_req.wdata = free_head_q;
          free_head_d    = blk_t;
          free_total_d   = free_total_q + FREE_W'(1);
        end else if (off_t != '0) begin
          tail_d = tail_q - POS_W'(1);
        end else begin
          walk_d         = blk_h;
          link_req.raddr = blk_h;
          state_d        = S_REM_WALK;
        end
      end

      // find the block whose link points at the tail block
      S_REM_WALK: begin
        if (link_rdata == blk_t) begin
          link_req.we    = 1'b1;
          link_req.waddr = blk_t;
          link_req.wdata = free_head_q;
          free_head_d    = blk_t;
          free_total_d   = free_total_q + FREE_W'(1);
          tail_d         = {walk_q, {OFF_W{1'b1}}};
          state_d        = S_FINISH;
        end else begin
          walk_d         = link_rdata;
          link_req.raddr = link_rdata;
        end
      end

      S_FL_EVAL: begin
        if (cnt_q == '0 || len_q == '0) begin
          state_d = S_FINISH;
        end else if (cnt_q >= rem) begin
          link_req.raddr = blk_h;
          state_d        = S_FL_LINK;
        end else begin
          len_d   = len_q - cnt_q;
          head_d  = head_q + POS_W'(cnt_q);
          state_d = S_FINISH;
        end
      end

      S_FL_LINK: begin
        cnt_d          = cnt_q - rem;
        len_d          = len_q - rem;
        link_req.we    = 1'b1;
        link_req.waddr = blk_h;
        link_req.wdata = free_head_q;
        free_head_d    = blk_h;
        free_total_d   = free_total_q + FREE_W'(1);
        head_d         = {link_rdata, {OFF_W{1'b0}}};
        state_d        = S_FL_EVAL;
      end

      S_CNT_SCAN: begin
        if (LEN_W'(idx_q) == count_q) begin
          state_d = S_FINISH;
        end else begin
          byte_req.raddr = head_q + POS_W'(idx_q);
          state_d        = S_CNT_CHK;
        end
      end

      S_CNT_CHK: begin
        if ((byte_rdata & mask_q) != '0) begin
          count_d = LEN_W'(idx_q);
          state_d = S_FINISH;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_CNT_SCAN;
        end
      end

      S_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          commit       = 1'b1;
          rsp_valid_d  = 1'b1;
          rsp_data_d   = data_q;
          rsp_status_d = status_q;
          rsp_count_d  = (cmd_q == CMD_COUNT) ? count_q : len_q;
          rsp_free_d   = free_total_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_head_q  <= '0;
      free_total_q <= FREE_W'(NUM_BLOCKS);
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      free_total_q <= free_total_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    qid_q        <= qid_d;
    din_q        <= din_d;
    cnt_q        <= cnt_d;
    mask_q       <= mask_d;
    len_q        <= len_d;
    head_q       <= head_d;
    tail_q       <= tail_d;
    data_q       <= data_d;
    status_q     <= status_d;
    count_q      <= count_d;
    walk_q       <= walk_d;
    idx_q        <= idx_d;
    rsp_data_q   <= rsp_data_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
    rsp_free_q   <= rsp_free_d;
  end

  // emptied queues go back to position zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qlen_q[i]  <= '0;
        qhead_q[i] <= '0;
        qtail_q[i] <= '0;
      end
    end else if (commit) begin
      qlen_q[qid_q]  <= len_q;
      qhead_q[qid_q] <= (len_q == '0) ? '0 : head_q;
      qtail_q[qid_q] <= (len_q == '0) ? '0 : tail_q;
    end
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= FREE_W'(NUM_BLOCKS))
    else $error("free block count above pool size");

  a_take_has_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT_TAKE |-> free_total_q != '0)
    else $error("block taken from an empty free list");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && cmd_q == CMD_COUNT) |-> count_q <= LEN_W'(BLOCK_BYTES))
    else $error("contiguous count exceeds block size");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> len_q <= LEN_W'(POOL_BYTES))
    else $error("queue length exceeds pool size");

endmodule
